>>> hw/rtl/mi3_pkg.sv
`timescale 1ns / 1ps

package mi3_pkg;

    // matrix order and entry count
    localparam int DIM   = 3;
    localparam int N_ENT = DIM * DIM;

    // front end depth: products, cofactors, det products, det sum, magnitudes
    localparam int FRONT_STAGES = 5;

endpackage

>>> hw/rtl/mi3_front.sv
`timescale 1ns / 1ps

module mi3_front #(
    parameter int IN_WIDTH = 16,
    parameter int CW       = 2 * IN_WIDTH + 1,
    parameter int DW       = 3 * IN_WIDTH + 2
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [IN_WIDTH-1:0] m [mi3_pkg::DIM][mi3_pkg::DIM],
    output logic        [CW-1:0]       cmag [mi3_pkg::DIM][mi3_pkg::DIM],
    output logic                       rneg [mi3_pkg::DIM][mi3_pkg::DIM],
    output logic        [DW-1:0]       dmag,
    output logic                       singular
);
    import mi3_pkg::*;

    logic signed [2*IN_WIDTH-1:0] pa_reg [DIM][DIM];
    logic signed [2*IN_WIDTH-1:0] pb_reg [DIM][DIM];
    logic signed [IN_WIDTH-1:0]   row1_reg [DIM];
    logic signed [IN_WIDTH-1:0]   row2_reg [DIM];
    logic signed [CW-1:0]         cof_reg [DIM][DIM];
    logic signed [CW-1:0]         cof3_reg [DIM][DIM];
    logic signed [CW-1:0]         cof4_reg [DIM][DIM];
    logic signed [DW-1:0]         dp_reg [DIM];
    logic signed [DW-1:0]         det_reg;
    logic signed [DW-1:0]         det_next;
    logic        [CW-1:0]         cmag_reg [DIM][DIM];
    logic                         rneg_reg [DIM][DIM];
    logic        [DW-1:0]         dmag_reg;
    logic                         sing_reg;
    logic                         dneg;

    // cofactor products, entry i,j is the numerator of result i,j
    for (genvar i = 0; i < DIM; i++) begin : g_pi
        for (genvar j = 0; j < DIM; j++) begin : g_pj
            localparam int I1 = (i + 1) % DIM;
            localparam int I2 = (i + 2) % DIM;
            localparam int J1 = (j + 1) % DIM;
            localparam int J2 = (j + 2) % DIM;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pa_reg[i][j] <= m[J1][I1] * m[J2][I2];
                    pb_reg[i][j] <= m[J1][I2] * m[J2][I1];
                end
            end
        end
    end

    // first row travels along for the determinant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row1_reg <= m[0];
            row2_reg <= row1_reg;
        end
    end

    // cofactor differences
    for (genvar i = 0; i < DIM; i++) begin : g_ci
        for (genvar j = 0; j < DIM; j++) begin : g_cj
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cof_reg[i][j]  <= CW'(pa_reg[i][j]) - CW'(pb_reg[i][j]);
                    cof3_reg[i][j] <= cof_reg[i][j];
                    cof4_reg[i][j] <= cof3_reg[i][j];
                end
            end
        end
    end

    // determinant terms along the first row
    for (genvar i = 0; i < DIM; i++) begin : g_di
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dp_reg[i] <= DW'(row2_reg[i]) * DW'(cof_reg[i][0]);
            end
        end
    end

    assign det_next = dp_reg[0] + dp_reg[1] + dp_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= det_next;
        end
    end

    // magnitudes and result signs
    assign dneg = det_reg[DW-1];

    for (genvar i = 0; i < DIM; i++) begin : g_mi
        for (genvar j = 0; j < DIM; j++) begin : g_mj
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cmag_reg[i][j] <= cof4_reg[i][j][CW-1] ? CW'(-cof4_reg[i][j])
                                                           : CW'(cof4_reg[i][j]);
                    rneg_reg[i][j] <= cof4_reg[i][j][CW-1] ^ dneg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg <= dneg ? DW'(-det_reg) : DW'(det_reg);
            sing_reg <= (det_reg == '0);
        end
    end

    assign cmag     = cmag_reg;
    assign rneg     = rneg_reg;
    assign dmag     = dmag_reg;
    assign singular = sing_reg;

endmodule

>>> hw/rtl/mi3_div_lane.sv
`timescale 1ns / 1ps

module mi3_div_lane #(
    parameter int CW        = 33,
    parameter int DW        = 50,
    parameter int SHIFT     = 24,
    parameter int OUT_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [CW-1:0]        cmag,
    input  logic                 neg,
    input  logic [DW-1:0]        dmag,
    output logic [OUT_WIDTH-1:0] val,
    output logic                 sat
);
    import mi3_pkg::*;

    localparam int NW = CW + SHIFT;
    localparam int XW = (NW > OUT_WIDTH) ? NW : OUT_WIDTH;
    localparam logic [XW-1:0] PMAX = XW'({1'b0, {(OUT_WIDTH-1){1'b1}}});
    localparam logic [XW-1:0] NMAX = PMAX + XW'(1);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] q_reg   [NW];
    logic [DW-1:0] d_reg   [NW];
    logic          neg_reg [NW];

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < NW; k++) begin : g_st
        logic [DW-1:0] r_in;
        logic [NW-1:0] n_in;
        logic [NW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic          s_in;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign r_in = '0;
            assign n_in = {cmag, {SHIFT{1'b0}}};
            assign q_in = '0;
            assign d_in = dmag;
            assign s_in = neg;
        end else begin : g_rest
            assign r_in = rem_reg[k-1];
            assign n_in = num_reg[k-1];
            assign q_in = q_reg[k-1];
            assign d_in = d_reg[k-1];
            assign s_in = neg_reg[k-1];
        end

        assign trial = {r_in, n_in[NW-1]};
        assign ge    = (trial >= {1'b0, d_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? DW'(trial - {1'b0, d_in}) : DW'(trial);
                num_reg[k] <= {n_in[NW-2:0], 1'b0};
                q_reg[k]   <= {q_in[NW-2:0], ge};
                d_reg[k]   <= d_in;
                neg_reg[k] <= s_in;
            end
        end
    end

    // sign and clip to the output range
    logic [XW-1:0]        qx;
    logic [XW-1:0]        qneg;
    logic                 negv;
    logic [OUT_WIDTH-1:0] val_next;
    logic                 sat_next;
    logic [OUT_WIDTH-1:0] val_reg;
    logic                 sat_reg;

    assign qx   = XW'(q_reg[NW-1]);
    assign qneg = XW'(0) - qx;
    assign negv = neg_reg[NW-1] && (qx != '0);

    always_comb
    begin
        if (!negv)
        begin
            sat_next = (qx > PMAX);
            val_next = sat_next ? PMAX[OUT_WIDTH-1:0] : qx[OUT_WIDTH-1:0];
        end
        else
        begin
            sat_next = (qx > NMAX);
            val_next = sat_next ? {1'b1, {(OUT_WIDTH-1){1'b0}}} : qneg[OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
            sat_reg <= sat_next;
        end
    end

    assign val = val_reg;
    assign sat = sat_reg;

endmodule

>>> hw/rtl/matrix3x3_inverse.sv
`timescale 1ns / 1ps
// channel   dir  signals                  fields (lowest bit up)
// s_axis    in   tvalid tready tdata      m00 m01 m02 m10 m11 m12 m20 m21 m22
// m_axis    out  tvalid tready tdata      r00 r01 r02 r10 r11 r12 r20 r21 r22
//                       tuser             singular saturated
//
// one matrix per cycle while the skid register is empty; the pipeline is:
//   5 front-end stages, NW = 2*IN_WIDTH+1 + IN_WIDTH/2 + OUT_WIDTH/2 divider
//   stages (one quotient bit each, nine lanes), 1 clip stage and 1 output register
// rst_n clears only the valid bits; data registers are not reset
// when the output stalls, one further result lands in a skid register and
//   the whole pipe then holds until the output drains

module matrix3x3_inverse #(
    parameter int IN_WIDTH  = 16,
    parameter int OUT_WIDTH = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22
    input  logic [((mi3_pkg::N_ENT*IN_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // r00 r01 r02 r10 r11 r12 r20 r21 r22
    output logic [((mi3_pkg::N_ENT*OUT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // singular saturated
    output logic [1:0]                                  m_axis_tuser
);
    import mi3_pkg::*;

    localparam int CW    = 2 * IN_WIDTH + 1;
    localparam int DW    = 3 * IN_WIDTH + 2;
    localparam int SHIFT = IN_WIDTH / 2 + OUT_WIDTH / 2;
    localparam int NW    = CW + SHIFT;
    localparam int LAT   = FRONT_STAGES + NW + 1;
    localparam int SDW   = ((N_ENT * IN_WIDTH + 7) / 8) * 8;
    localparam int MDW   = ((N_ENT * OUT_WIDTH + 7) / 8) * 8;
    localparam int SLAT  = NW + 1;

    logic                       adv;
    logic signed [IN_WIDTH-1:0] m [DIM][DIM];
    logic        [CW-1:0]       cmag [DIM][DIM];
    logic                       rneg [DIM][DIM];
    logic        [DW-1:0]       dmag;
    logic                       fe_sing;
    logic [OUT_WIDTH-1:0]       lval [N_ENT];
    logic                       lsat [N_ENT];
    logic [LAT-1:0]             vld_reg;
    logic [SLAT-1:0]            sing_reg;

    // unpack the input beat
    for (genvar i = 0; i < DIM; i++) begin : g_ui
        for (genvar j = 0; j < DIM; j++) begin : g_uj
            assign m[i][j] = s_axis_tdata[(i*DIM+j)*IN_WIDTH +: IN_WIDTH];
        end
    end

    mi3_front #(
        .IN_WIDTH (IN_WIDTH),
        .CW       (CW),
        .DW       (DW)
    ) u_front (
        .clk      (clk),
        .en       (adv),
        .m        (m),
        .cmag     (cmag),
        .rneg     (rneg),
        .dmag     (dmag),
        .singular (fe_sing)
    );

    // nine divider lanes share the determinant
    for (genvar i = 0; i < DIM; i++) begin : g_li
        for (genvar j = 0; j < DIM; j++) begin : g_lj
            mi3_div_lane #(
                .CW        (CW),
                .DW        (DW),
                .SHIFT     (SHIFT),
                .OUT_WIDTH (OUT_WIDTH)
            ) u_lane (
                .clk  (clk),
                .en   (adv),
                .cmag (cmag[i][j]),
                .neg  (rneg[i][j]),
                .dmag (dmag),
                .val  (lval[i*DIM+j]),
                .sat  (lsat[i*DIM+j])
            );
        end
    end

    // beat valid and singular flag follow the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sing_reg <= {sing_reg[SLAT-2:0], fe_sing};
        end
    end

    // merge the lanes into one result beat
    logic [MDW-1:0] res_data;
    logic [1:0]     res_user;
    logic           any_sat;

    always_comb
    begin
        res_data = '0;
        any_sat  = 1'b0;
        for (int k = 0; k < N_ENT; k++)
        begin
            res_data[k*OUT_WIDTH +: OUT_WIDTH] = sing_reg[SLAT-1] ? '0 : lval[k];
            any_sat = any_sat | lsat[k];
        end
        res_user = {any_sat & ~sing_reg[SLAT-1], sing_reg[SLAT-1]};
    end

    // output register plus skid register
    logic           out_valid_reg;
    logic           skid_valid_reg;
    logic [MDW-1:0] out_data_reg;
    logic [1:0]     out_user_reg;
    logic [MDW-1:0] skid_data_reg;
    logic [1:0]     skid_user_reg;
    logic           out_take;
    logic           last_vld;
    logic           load_out;
    logic           load_skid;
    logic           skid_to_out;

    assign adv         = ~skid_valid_reg;
    assign out_take    = out_valid_reg & m_axis_tready;
    assign last_vld    = vld_reg[LAT-1];
    assign skid_to_out = skid_valid_reg & out_take;
    assign load_out    = adv & last_vld & (~out_valid_reg | out_take);
    assign load_skid   = adv & last_vld & out_valid_reg & ~out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_to_out)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (load_skid)
            begin
                skid_valid_reg <= 1'b1;
            end

            if (load_out || skid_to_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_to_out)
        begin
            out_data_reg <= skid_data_reg;
            out_user_reg <= skid_user_reg;
        end
        else if (load_out)
        begin
            out_data_reg <= res_data;
            out_user_reg <= res_user;
        end

        if (load_skid)
        begin
            skid_data_reg <= res_data;
            skid_user_reg <= res_user;
        end
    end

    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // singular results carry zero entries and no saturation
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
        else $error("singular beat with nonzero payload");

    // skid only ever holds a beat behind a waiting output
    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full while output empty");

    // a finished beat that meets a stalled output lands in the skid
    a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
        last_vld && adv && out_valid_reg && !m_axis_tready |=> skid_valid_reg)
        else $error("result dropped on stall");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 32;
    localparam int IN_BW  = ((mi3_pkg::N_ENT * IN_W + 7) / 8) * 8;
    localparam int OUT_BW = ((mi3_pkg::N_ENT * OUT_W + 7) / 8) * 8;
    localparam int FRAC_SHIFT = IN_W / 2 + OUT_W / 2;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic [OUT_BW-1:0] ent;
        logic [1:0]        flags;   // singular saturated
    } inverse_t;

    typedef struct {
        int m[9];
        bit typed;      // expected value written out below
        int diag;       // typed: diagonal of inverse, off-diagonal zero
        bit sing;
        bit sat;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_BW-1:0]  s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_BW-1:0] m_axis_tdata;
    logic [1:0]        m_axis_tuser;

    inverse_t expected_inverses[$];
    int       fail_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_left = 0;
    int       quiet_cycles = 0;

    always #5 clk = ~clk;

    matrix3x3_inverse #(.IN_WIDTH(IN_W), .OUT_WIDTH(OUT_W)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    // exact adjugate inverse of one matrix beat
    function automatic inverse_t invert_matrix(input logic [IN_BW-1:0] d);
        inverse_t res;
        longint a[3][3];
        longint cof[3][3];
        longint det;
        longint unsigned num;
        longint unsigned dmag;
        longint unsigned q;
        longint v;
        bit rneg;
        bit sat;
        int i1, i2, j1, j2;
        res.ent = '0;
        sat = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = longint'($signed(d[(i*3+j)*IN_W +: IN_W]));
        for (int i = 0; i < 3; i++)
        begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++)
            begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                cof[i][j] = a[j1][i1] * a[j2][i2] - a[j1][i2] * a[j2][i1];
            end
        end
        det = 0;
        for (int i = 0; i < 3; i++)
            det += a[0][i] * cof[i][0];
        if (det == 0)
        begin
            res.flags = 2'b01;
            return res;
        end
        dmag = (det < 0) ? longint'(-det) : longint'(det);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                num = (cof[i][j] < 0) ? longint'(-cof[i][j]) : longint'(cof[i][j]);
                num = num << FRAC_SHIFT;
                q = num / dmag;
                rneg = ((cof[i][j] < 0) != (det < 0)) && (q != 0);
                if (!rneg)
                begin
                    if (q > 64'h7FFF_FFFF)
                    begin
                        v = 64'h7FFF_FFFF;
                        sat = 1'b1;
                    end
                    else
                        v = longint'(q);
                end
                else
                begin
                    if (q > 64'h8000_0000)
                    begin
                        v = -64'sh8000_0000;
                        sat = 1'b1;
                    end
                    else
                        v = -longint'(q);
                end
                res.ent[(i*3+j)*OUT_W +: OUT_W] = v[OUT_W-1:0];
            end
        res.flags = {sat, 1'b0};
        return res;
    endfunction

    function automatic logic [IN_BW-1:0] pack_matrix(input int m[9]);
        logic [IN_BW-1:0] d;
        d = '0;
        for (int k = 0; k < 9; k++)
            d[k*IN_W +: IN_W] = m[k][IN_W-1:0];
        return d;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // send one matrix beat, with a random idle gap first
    task automatic send_matrix(input logic [IN_BW-1:0] d, input inverse_t exp_res);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_inverses.insert(expected_inverses.size(), exp_res);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_predicted(input logic [IN_BW-1:0] d);
        send_matrix(d, invert_matrix(d));
    endtask

    task automatic wait_drained();
        while (expected_inverses.size() != 0)
            @(negedge clk);
    endtask

    // random matrix of one of several flavors
    function automatic logic [IN_BW-1:0] random_matrix();
        int m[9];
        int kind;
        int lim;
        kind = $urandom_range(99);
        lim = (kind < 60) ? 32767 : (kind < 80) ? 4 : 600;
        for (int k = 0; k < 9; k++)
            m[k] = (kind < 60) ? int'($urandom_range(65535)) - 32768
                               : int'($urandom_range(2 * lim)) - lim;
        if (kind >= 90)
        begin
            // repeated row gives a singular matrix
            for (int c = 0; c < 3; c++)
                m[6 + c] = m[c];
        end
        return pack_matrix(m);
    endfunction

    // receiver readiness, with random stalls and a long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        inverse_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_inverses.size() == 0)
            begin
                $display("unexpected result beat at %0t", $time);
                fail_count++;
            end
            else
            begin
                want = expected_inverses.pop_front();
                for (int k = 0; k < 9; k++)
                    if (m_axis_tdata[k*OUT_W +: OUT_W] !== want.ent[k*OUT_W +: OUT_W])
                        report_mismatch($sformatf("r%0d%0d", k / 3, k % 3),
                            longint'($signed(m_axis_tdata[k*OUT_W +: OUT_W])),
                            longint'($signed(want.ent[k*OUT_W +: OUT_W])));
                if (m_axis_tuser[0] !== want.flags[0])
                    report_mismatch("singular", m_axis_tuser[0], want.flags[0]);
                if (m_axis_tuser[1] !== want.flags[1])
                    report_mismatch("saturated", m_axis_tuser[1], want.flags[1]);
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("matrix3x3_inverse verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        inverse_t typed_res;
        int d;
        rows = '{
            // zero matrix is singular
            '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 1, 0},
            // identity
            '{'{256, 0, 0, 0, 256, 0, 0, 0, 256}, 1, 65536, 0, 0},
            // smallest diagonal
            '{'{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1, 16777216, 0, 0},
            // most negative diagonal
            '{'{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}, 1, -512, 0, 0},
            '{'{-256, 0, 0, 0, -256, 0, 0, 0, -256}, 1, -65536, 0, 0},
            // all equal entries are singular
            '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1, 0, 1, 0},
            '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
              1, 0, 1, 0},
            // near-singular and mixed matrices
            '{'{32767, 32767, 0, 32767, 32766, 0, 0, 0, 1}, 0, 0, 0, 0},
            '{'{-32768, 32767, 0, 32767, -32768, 0, 0, 0, -1}, 0, 0, 0, 0},
            '{'{1, 2, 3, 4, 5, 6, 7, 8, 10}, 0, 0, 0, 0},
            '{'{32767, -32768, 1, -1, 32767, -32768, -32768, 1, 32767}, 0, 0, 0, 0},
            '{'{-1, -1, 0, 0, -1, -1, -1, 0, -1}, 0, 0, 0, 0},
            '{'{21845, -21846, 13107, -13108, 255, -256, 4660, -4661, 1}, 0, 0, 0, 0},
            '{'{0, 256, 0, 0, 0, 256, 256, 0, 0}, 0, 0, 0, 0}
        };

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part
        foreach (rows[i])
        begin
            row = rows[i];
            if (row.typed)
            begin
                typed_res.ent = '0;
                for (int k = 0; k < 3; k++)
                    typed_res.ent[(k*4)*OUT_W +: OUT_W] = row.diag[OUT_W-1:0];
                typed_res.flags = {row.sat, row.sing};
                send_matrix(pack_matrix(row.m), typed_res);
            end
            else
                send_predicted(pack_matrix(row.m));
        end
        wait_drained();

        // random part in idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 68 : 33) : 0;
            recv_stall_pct = (ph == 2) ? 68 : (ph == 3) ? 33 : 0;
            // long receiver hold-off so the pipe fills and stalls the input
            if (ph == 0)
                hold_left = HOLD_CYCLES;
            for (int n = 0; n < 270; n++)
            begin
                send_predicted(random_matrix());
                // short stretch without idling inside each phase
                if (n == 135)
                begin
                    d = send_idle_pct;
                    send_idle_pct = 0;
                    repeat (20) send_predicted(random_matrix());
                    send_idle_pct = d;
                end
            end
            // sender pauses until all results are back
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_inverses.size() != 0)
        begin
            $display("%0d results never arrived", expected_inverses.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("matrix3x3_inverse verification clean");
        else
            $display("matrix3x3_inverse verification failed");
        $finish;
    end

endmodule

>>> matrix3x3_inverse.f
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_front.sv
hw/rtl/mi3_div_lane.sv
hw/rtl/matrix3x3_inverse.sv
tb/testbench.sv
